// ===== rtl/srcs_pkg.sv =====
package srcs_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = $clog2(REG_COUNT);

	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_MUL = 5'd2;
	localparam logic [4:0] OP_DIV = 5'd3;
	localparam logic [4:0] OP_AND = 5'd4;
	localparam logic [4:0] OP_OR  = 5'd5;
	localparam logic [4:0] OP_XOR = 5'd6;
	localparam logic [4:0] OP_SHF = 5'd7;
	localparam logic [4:0] OP_LDB = 5'd10;
	localparam logic [4:0] OP_LDW = 5'd11;
	localparam logic [4:0] OP_STB = 5'd12;
	localparam logic [4:0] OP_STW = 5'd13;
	localparam logic [4:0] OP_JMP = 5'd20;
	localparam logic [4:0] OP_JZ  = 5'd21;
	localparam logic [4:0] OP_JNZ = 5'd22;
	localparam logic [4:0] OP_JC  = 5'd23;
	localparam logic [4:0] OP_JNC = 5'd24;
	localparam logic [4:0] OP_JN  = 5'd25;
	localparam logic [4:0] OP_JNN = 5'd26;
	localparam logic [4:0] OP_IN  = 5'd27;
	localparam logic [4:0] OP_OUT = 5'd28;
	localparam logic [4:0] OP_RND = 5'd29;
	localparam logic [4:0] OP_HLT = 5'd31;

	localparam logic ACT_PROG = 1'b0;
	localparam logic ACT_EXEC = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISP,
		ST_PROG,
		ST_FETCH,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_DIVF,
		ST_LOAD,
		ST_STORE,
		ST_WB,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic       clear_wr;
		logic       take_in;
		logic       prog_wr;
		logic       fetch;
		logic       rd;
		logic       exec;
		logic       div_step;
		logic       div_fin;
		logic       load;
		logic       store;
		logic       wb;
		logic       put;
		logic [5:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic [4:0] op;
		logic       action;
		logic       halted;
		logic       b_zero;
		logic       dist_zero;
		logic       clr_last;
		logic       out_free;
	} sts_t;

endpackage

// ===== rtl/small_risc_core_step_core.sv =====
// small risc core, one item per step
// input channel: in_valid / in_stall, fields action, load_address, load_byte,
//   in_value and random_value; a transfer happens when in_valid is high and
//   in_stall low. an action 0 transfer writes one program byte, an action 1
//   transfer runs one instruction of the program in the byte memory
// result channel: res_valid / res_stall, one result per input transfer with
//   next_pc, out_valid, out_value, the flags, divide_fault and halted
// divide and random run through the 32-step shared divider; the fetch of
//   four bytes goes through the single memory read port. one item is in
//   flight at a time and the next transfer is taken in the cycle after the
//   result is loaded
// reset: arst_n clears pc, flags, halt and register valid bits, then the
//   byte memory is swept to zero one byte a cycle while in_stall stays
//   high
// a stalled result sits in the output register; the core then takes the
//   next transfer and works on it, holding its result until the
//   output register frees
module small_risc_core_step_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [15:0]         load_address,
	input  logic [7:0]          load_byte,
	input  logic signed [15:0]  in_value,
	input  logic [14:0]         random_value,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [15:0]         next_pc,
	output logic                out_valid,
	output logic signed [31:0]  out_value,
	output logic                flag_negative,
	output logic                flag_zero,
	output logic                flag_carry,
	output logic                divide_fault,
	output logic                halted
);

	// command and status between sequencer and datapath
	srcs_pkg::cmd_t cmd;
	srcs_pkg::sts_t sts;

	// sequencer: fetch, register read, execute, divide, memory, write back
	srcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath with byte memory, register file, alu, divider and output register
	srcs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.load_address  (load_address),
		.load_byte     (load_byte),
		.in_value      (in_value),
		.random_value  (random_value),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.next_pc       (next_pc),
		.out_valid     (out_valid),
		.out_value     (out_value),
		.flag_negative (flag_negative),
		.flag_zero     (flag_zero),
		.flag_carry    (flag_carry),
		.divide_fault  (divide_fault),
		.halted        (halted)
	);

endmodule

// ===== rtl/srcs_ctrl.sv =====
module srcs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  srcs_pkg::sts_t  sts,
	output srcs_pkg::cmd_t  cmd
);

	srcs_pkg::state_t state_q, state_nx;
	logic [5:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srcs_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= (state_nx != state_q) ? 6'd0 : cnt_q + 6'd1;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			srcs_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nx = srcs_pkg::ST_IDLE;
			end
			srcs_pkg::ST_IDLE: begin
				if (in_valid) state_nx = srcs_pkg::ST_DISP;
			end
			srcs_pkg::ST_DISP: begin
				if (sts.action == srcs_pkg::ACT_PROG) state_nx = srcs_pkg::ST_PROG;
				else if (sts.halted) state_nx = srcs_pkg::ST_PUT;
				else state_nx = srcs_pkg::ST_FETCH;
			end
			srcs_pkg::ST_PROG:  state_nx = srcs_pkg::ST_PUT;
			srcs_pkg::ST_FETCH: begin
				if (cnt_q == 6'd4) state_nx = srcs_pkg::ST_READ;
			end
			srcs_pkg::ST_READ: begin
				if (cnt_q == 6'd3) state_nx = srcs_pkg::ST_EXEC;
			end
			srcs_pkg::ST_EXEC: begin
				if ((sts.op == srcs_pkg::OP_DIV && !sts.b_zero) ||
				    (sts.op == srcs_pkg::OP_RND && !sts.dist_zero))
					state_nx = srcs_pkg::ST_DIV;
				else if (sts.op == srcs_pkg::OP_LDB || sts.op == srcs_pkg::OP_LDW)
					state_nx = srcs_pkg::ST_LOAD;
				else if (sts.op == srcs_pkg::OP_STB || sts.op == srcs_pkg::OP_STW)
					state_nx = srcs_pkg::ST_STORE;
				else
					state_nx = srcs_pkg::ST_WB;
			end
			srcs_pkg::ST_DIV: begin
				if (cnt_q == 6'd31) state_nx = srcs_pkg::ST_DIVF;
			end
			srcs_pkg::ST_DIVF: state_nx = srcs_pkg::ST_WB;
			srcs_pkg::ST_LOAD: begin
				if ((sts.op == srcs_pkg::OP_LDB && cnt_q == 6'd1) || cnt_q == 6'd2)
					state_nx = srcs_pkg::ST_WB;
			end
			srcs_pkg::ST_STORE: begin
				if (sts.op == srcs_pkg::OP_STB || cnt_q == 6'd1)
					state_nx = srcs_pkg::ST_WB;
			end
			srcs_pkg::ST_WB:  state_nx = srcs_pkg::ST_PUT;
			srcs_pkg::ST_PUT: begin
				if (sts.out_free) state_nx = srcs_pkg::ST_IDLE;
			end
			default: state_nx = srcs_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd          = '0;
		cmd.cnt      = cnt_q;
		in_stall     = (state_q != srcs_pkg::ST_IDLE);
		case (state_q)
			srcs_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
			srcs_pkg::ST_IDLE:  cmd.take_in  = in_valid;
			srcs_pkg::ST_PROG:  cmd.prog_wr  = 1'b1;
			srcs_pkg::ST_FETCH: cmd.fetch    = 1'b1;
			srcs_pkg::ST_READ:  cmd.rd       = 1'b1;
			srcs_pkg::ST_EXEC:  cmd.exec     = 1'b1;
			srcs_pkg::ST_DIV:   cmd.div_step = 1'b1;
			srcs_pkg::ST_DIVF:  cmd.div_fin  = 1'b1;
			srcs_pkg::ST_LOAD:  cmd.load     = 1'b1;
			srcs_pkg::ST_STORE: cmd.store    = 1'b1;
			srcs_pkg::ST_WB:    cmd.wb       = 1'b1;
			srcs_pkg::ST_PUT:   cmd.put      = sts.out_free;
			default: cmd.cnt = cnt_q;
		endcase
	end

endmodule

// ===== rtl/srcs_dp.sv =====
module srcs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  srcs_pkg::cmd_t      cmd,
	output srcs_pkg::sts_t      sts,
	input  logic                action,
	input  logic [15:0]         load_address,
	input  logic [7:0]          load_byte,
	input  logic signed [15:0]  in_value,
	input  logic [14:0]         random_value,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [15:0]         next_pc,
	output logic                out_valid,
	output logic signed [31:0]  out_value,
	output logic                flag_negative,
	output logic                flag_zero,
	output logic                flag_carry,
	output logic                divide_fault,
	output logic                halted
);

	localparam int AW = srcs_pkg::MEM_AW;
	localparam int RW = srcs_pkg::REG_AW;

	// storage
	logic [7:0]  mem [srcs_pkg::MEM_BYTES];
	logic [31:0] rf  [srcs_pkg::REG_COUNT];
	logic [srcs_pkg::REG_COUNT-1:0] rf_vld_q;

	// item registers
	logic        act_q;
	logic [15:0] ladr_q;
	logic [7:0]  lbyte_q;
	logic [15:0] inv_q;
	logic [14:0] rnd_q;

	// architectural state
	logic [15:0] pc_q;
	logic [2:0]  flags_q;
	logic        halt_q;
	logic [AW-1:0] clr_q;

	// working registers
	logic [31:0] ir_q, a_q, b_q, d_q, res_q, lo_q, quo_q, dvs_q, rem_q;
	logic [15:0] ea_q;
	logic        shc_q, shf_q, sgn_q, fault_q, outv_q;
	logic [7:0]  mem_rd_q;
	logic [31:0] rf_rd_q;
	logic        rf_rv_q;

	// output register
	logic        ov_q;
	logic [15:0] o_pc_q;
	logic        o_outv_q, o_n_q, o_z_q, o_c_q, o_fault_q, o_halt_q;
	logic [31:0] o_val_q;

	// decode
	logic [4:0]  op, dst, s1;
	logic        imm;
	logic [31:0] opnd_x, rf_val;
	assign op     = ir_q[31:27];
	assign dst    = ir_q[26:22];
	assign s1     = ir_q[21:17];
	assign imm    = ir_q[16];
	assign opnd_x = {{16{ir_q[15]}}, ir_q[15:0]};
	assign rf_val = rf_rv_q ? rf_rd_q : 32'd0;

	// random range
	logic [31:0] sa, sb;
	logic        a_less;
	logic [16:0] span;
	assign sa     = {{16{a_q[15]}}, a_q[15:0]};
	assign sb     = {{16{b_q[15]}}, b_q[15:0]};
	assign a_less = $signed(a_q[15:0]) < $signed(b_q[15:0]);
	assign span   = a_less ? ({b_q[15], b_q[15:0]} - {a_q[15], a_q[15:0]})
	                       : ({a_q[15], a_q[15:0]} - {b_q[15], b_q[15:0]});

	// 16-bit shift with carry from last bit out
	logic [31:0] sh_k, sh_wl;
	logic signed [31:0] sh_wr;
	logic [4:0]  sh_k5;
	logic [15:0] sh_r;
	logic        sh_c;
	always_comb begin
		sh_k  = b_q[31] ? (32'd0 - b_q) : b_q;
		sh_k5 = (sh_k > 32'd16) ? 5'd16 : sh_k[4:0];
		sh_wl = {16'd0, a_q[15:0]} << sh_k5;
		sh_wr = $signed({a_q[15:0], 16'd0}) >>> sh_k5;
		if (b_q == 32'd0) begin
			sh_r = a_q[15:0];
			sh_c = 1'b0;
		end else if (!b_q[31]) begin
			sh_r = (sh_k > 32'd16) ? 16'd0 : sh_wl[15:0];
			sh_c = (sh_k > 32'd16) ? 1'b0 : sh_wl[16];
		end else begin
			sh_r = sh_wr[31:16];
			sh_c = sh_wr[15];
		end
	end

	// immediate result of the execute step
	logic [31:0] ex_r, a_mag, b_mag;
	logic [15:0] mul_r;
	assign a_mag = a_q[31] ? (32'd0 - a_q) : a_q;
	assign b_mag = b_q[31] ? (32'd0 - b_q) : b_q;
	assign mul_r = a_q[7:0] * b_q[7:0];
	always_comb begin
		case (op)
			srcs_pkg::OP_ADD: ex_r = a_q + b_q;
			srcs_pkg::OP_SUB: ex_r = a_q - b_q;
			srcs_pkg::OP_MUL: ex_r = {16'd0, mul_r};
			srcs_pkg::OP_AND: ex_r = a_q & b_q;
			srcs_pkg::OP_OR:  ex_r = a_q | b_q;
			srcs_pkg::OP_XOR: ex_r = a_q ^ b_q;
			srcs_pkg::OP_SHF: ex_r = {{16{sh_r[15]}}, sh_r};
			srcs_pkg::OP_RND: ex_r = a_less ? sa : sb;
			srcs_pkg::OP_STB: ex_r = {{24{a_q[7]}}, a_q[7:0]};
			srcs_pkg::OP_STW: ex_r = {{16{a_q[15]}}, a_q[15:0]};
			srcs_pkg::OP_IN:  ex_r = {{16{inv_q[15]}}, inv_q};
			srcs_pkg::OP_OUT: ex_r = d_q;
			default:          ex_r = 32'd0;
		endcase
	end

	// class of the instruction
	logic wr_reg, wr_flags, take;
	always_comb begin
		case (op)
			srcs_pkg::OP_ADD, srcs_pkg::OP_SUB, srcs_pkg::OP_MUL, srcs_pkg::OP_DIV,
			srcs_pkg::OP_AND, srcs_pkg::OP_OR, srcs_pkg::OP_XOR, srcs_pkg::OP_SHF,
			srcs_pkg::OP_LDB, srcs_pkg::OP_LDW, srcs_pkg::OP_IN, srcs_pkg::OP_RND: begin
				wr_reg   = 1'b1;
				wr_flags = 1'b1;
			end
			srcs_pkg::OP_STB, srcs_pkg::OP_STW, srcs_pkg::OP_OUT: begin
				wr_reg   = 1'b0;
				wr_flags = 1'b1;
			end
			default: begin
				wr_reg   = 1'b0;
				wr_flags = 1'b0;
			end
		endcase
		case (op)
			srcs_pkg::OP_JMP: take = 1'b1;
			srcs_pkg::OP_JZ:  take = flags_q[1];
			srcs_pkg::OP_JNZ: take = !flags_q[1];
			srcs_pkg::OP_JC:  take = flags_q[0];
			srcs_pkg::OP_JNC: take = !flags_q[0];
			srcs_pkg::OP_JN:  take = flags_q[2];
			srcs_pkg::OP_JNN: take = !flags_q[2];
			default:          take = 1'b0;
		endcase
	end

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd;
	logic [15:0]   fa, la;
	assign fa = pc_q + {14'd0, cmd.cnt[1:0]};
	assign la = ea_q + {15'd0, cmd.cnt[0]};
	assign mem_ra = cmd.fetch ? fa[AW-1:0] : la[AW-1:0];
	always_comb begin
		mem_we = cmd.clear_wr | cmd.prog_wr | cmd.store;
		mem_wa = la[AW-1:0];
		mem_wd = cmd.cnt[0] ? a_q[15:8] : a_q[7:0];
		if (cmd.clear_wr) begin
			mem_wa = clr_q;
			mem_wd = 8'd0;
		end else if (cmd.prog_wr) begin
			mem_wa = ladr_q[AW-1:0];
			mem_wd = lbyte_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// register file ports
	logic [RW-1:0] rf_ra;
	logic          rf_we;
	always_comb begin
		case (cmd.cnt[1:0])
			2'd0:    rf_ra = s1;
			2'd1:    rf_ra = ir_q[RW-1:0];
			default: rf_ra = dst;
		endcase
	end
	assign rf_we = cmd.wb && wr_reg && (dst != '0);

	always_ff @(posedge clk) begin
		if (rf_we) rf[dst] <= res_q;
		rf_rd_q <= rf[rf_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			rf_rv_q  <= 1'b0;
		end else begin
			if (rf_we) rf_vld_q[dst] <= 1'b1;
			rf_rv_q <= rf_vld_q[rf_ra];
		end
	end

	// divider step
	logic [32:0] dv_t, dv_d;
	assign dv_t = {rem_q, quo_q[31]};
	assign dv_d = dv_t - {1'b0, dvs_q};

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			act_q   <= action;
			ladr_q  <= load_address;
			lbyte_q <= load_byte;
			inv_q   <= in_value;
			rnd_q   <= random_value;
		end
		if (cmd.fetch && cmd.cnt != 6'd0) ir_q <= {ir_q[23:0], mem_rd_q};
		if (cmd.rd) begin
			case (cmd.cnt[1:0])
				2'd1:    a_q <= rf_val;
				2'd2:    b_q <= imm ? opnd_x : rf_val;
				2'd3:    d_q <= rf_val;
				default: a_q <= a_q;
			endcase
		end
		if (cmd.exec) begin
			res_q <= ex_r;
			shc_q <= sh_c;
			shf_q <= (op == srcs_pkg::OP_SHF);
			lo_q  <= a_less ? sa : sb;
			sgn_q <= a_q[31] ^ b_q[31];
			ea_q  <= ((op == srcs_pkg::OP_LDB || op == srcs_pkg::OP_LDW) ? a_q[15:0]
			                                                             : d_q[15:0])
			         + b_q[15:0];
			rem_q <= 32'd0;
			if (op == srcs_pkg::OP_RND) begin
				quo_q <= {17'd0, rnd_q};
				dvs_q <= {15'd0, span};
			end else begin
				quo_q <= a_mag;
				dvs_q <= b_mag;
			end
		end
		if (cmd.div_step) begin
			if (!dv_d[32]) begin
				rem_q <= dv_d[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= dv_t[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.div_fin) begin
			if (op == srcs_pkg::OP_RND) res_q <= lo_q + rem_q;
			else res_q <= sgn_q ? (32'd0 - quo_q) : quo_q;
		end
		if (cmd.load) begin
			if (cmd.cnt == 6'd1) res_q <= {{24{mem_rd_q[7]}}, mem_rd_q};
			else if (cmd.cnt == 6'd2) res_q <= {{16{mem_rd_q[7]}}, mem_rd_q, res_q[7:0]};
		end
	end

	// architectural and control state
	logic f_c;
	assign f_c = shf_q ? shc_q : !((&res_q[31:15]) || (res_q[31:15] == 17'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			flags_q <= '0;
			halt_q  <= 1'b0;
			clr_q   <= '0;
			fault_q <= 1'b0;
			outv_q  <= 1'b0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.take_in) begin
				fault_q <= 1'b0;
				outv_q  <= 1'b0;
			end
			if (cmd.exec) begin
				fault_q <= (op == srcs_pkg::OP_DIV && b_q == 32'd0) ||
				           (op == srcs_pkg::OP_RND && span == 17'd0);
				outv_q  <= (op == srcs_pkg::OP_OUT);
			end
			if (cmd.wb) begin
				pc_q <= take ? b_q[15:0] : pc_q + 16'd4;
				if (wr_flags) flags_q <= {res_q[31], res_q == 32'd0, f_c};
				if (op == srcs_pkg::OP_HLT) halt_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.put) begin
			ov_q <= 1'b1;
		end else if (!res_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			o_pc_q    <= pc_q;
			o_outv_q  <= outv_q;
			o_val_q   <= outv_q ? d_q : 32'd0;
			o_n_q     <= flags_q[2];
			o_z_q     <= flags_q[1];
			o_c_q     <= flags_q[0];
			o_fault_q <= fault_q;
			o_halt_q  <= halt_q;
		end
	end

	assign res_valid     = ov_q;
	assign next_pc       = o_pc_q;
	assign out_valid     = o_outv_q;
	assign out_value     = o_val_q;
	assign flag_negative = o_n_q;
	assign flag_zero     = o_z_q;
	assign flag_carry    = o_c_q;
	assign divide_fault  = o_fault_q;
	assign halted        = o_halt_q;

	assign sts.op        = op;
	assign sts.action    = act_q;
	assign sts.halted    = halt_q;
	assign sts.b_zero    = (b_q == 32'd0);
	assign sts.dist_zero = (span == 17'd0);
	assign sts.clr_last  = &clr_q;
	assign sts.out_free  = !ov_q || !res_stall;

endmodule
